>>> rtl/assert_macros.svh
// Assertion helpers used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define IPO_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define IPO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ipo_pkg.sv
// ----------------------------------------------------------------------------
// ipo_pkg
// Types, constants and helper functions of the patch output-size checker.
// ----------------------------------------------------------------------------
package ipo_pkg;

   localparam int SIZE_W = 26;
   localparam int CMP_W  = 27;
   localparam logic [CMP_W-1:0] MAX_OUTPUT = 27'd33554432;
   localparam logic [23:0] EOF_MARK = 24'h454F46;
   localparam logic [2:0] HDR_LEN = 3'd5;

   typedef enum logic [5:0] {
      PH_HEADER  = 6'b000001,
      PH_RECORD  = 6'b000010,
      PH_SIZE    = 6'b000100,
      PH_RLE     = 6'b001000,
      PH_DATA    = 6'b010000,
      PH_TRAILER = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] patch_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic              ok;
      logic [SIZE_W-1:0] output_size;
   } result_type;

   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h50;
         3'd1: c = 8'h41;
         3'd2: c = 8'h54;
         3'd3: c = 8'h43;
         3'd4: c = 8'h48;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/ipo_in_stage.sv
// ----------------------------------------------------------------------------
// ipo_in_stage
// Input register that holds one request until the parser takes it.
// ----------------------------------------------------------------------------
module ipo_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              take,
   output logic              item_valid,
   output ipo_pkg::item_type item
);
   import ipo_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in        = 1'b1;
         item_in.patch_byte = req_tdata;
         item_in.last_byte  = req_tlast;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/ipo_parser.sv
// ----------------------------------------------------------------------------
// ipo_parser
// Parser state, size tracking and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipo_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [25:0]         csr_wdata,
   input  logic                item_valid,
   input  ipo_pkg::item_type   item,
   output logic                take,
   input  logic                rsp_tready,
   output logic                rsp_valid,
   output ipo_pkg::result_type result
);
   import ipo_pkg::*;

   logic [SIZE_W-1:0] input_size_ff;
   phase_type         phase_ff, phase_in;
   logic [1:0]        fbc_ff, fbc_in;
   logic [23:0]       off_ff, off_in;
   logic [15:0]       size_ff, size_in;
   logic [15:0]       skip_ff, skip_in;
   logic [SIZE_W-1:0] max_end_ff, max_end_in;
   logic [23:0]       expl_ff, expl_in;
   logic [2:0]        tc_ff, tc_in;
   logic [2:0]        total_ff, total_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff, result_in;

   logic [SIZE_W-1:0] max_cur;
   logic [CMP_W-1:0]  rec_end;
   logic [23:0]       off_shift;
   logic [15:0]       size_shift;
   logic [15:0]       skip_dec;
   logic              finish;
   logic              last_take;

   assign take = item_valid && (!item.last_byte || !rsp_valid_ff || rsp_tready);
   assign last_take = take && item.last_byte;

   assign max_cur = (phase_ff == PH_HEADER && total_ff == 3'd0 && !err_ff)
                    ? input_size_ff : max_end_ff;
   assign rec_end    = CMP_W'(off_ff) + CMP_W'(size_ff);
   assign off_shift  = {off_ff[15:0], item.patch_byte};
   assign size_shift = {size_ff[7:0], item.patch_byte};
   assign skip_dec   = (skip_ff != 16'd0) ? skip_ff - 16'd1 : skip_ff;

   always_comb begin
      phase_in   = phase_ff;
      fbc_in     = fbc_ff;
      off_in     = off_ff;
      size_in    = size_ff;
      skip_in    = skip_ff;
      max_end_in = max_end_ff;
      expl_in    = expl_ff;
      tc_in      = tc_ff;
      total_in   = total_ff;
      err_in     = err_ff;
      finish     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         max_end_in = max_cur;
         if (!err_ff) begin
            case (phase_ff)
               PH_HEADER: begin
                  if (total_ff >= HDR_LEN || item.patch_byte != hdr_char(total_ff)) begin
                     err_in = 1'b1;
                  end else begin
                     total_in = total_ff + 3'd1;
                     if (total_ff == HDR_LEN - 3'd1) begin
                        phase_in = PH_RECORD;
                        fbc_in   = 2'd0;
                        off_in   = 24'd0;
                     end
                  end
               end
               PH_RECORD: begin
                  off_in = off_shift;
                  if (fbc_ff >= 2'd2) begin
                     fbc_in = 2'd0;
                     if (off_shift == EOF_MARK) begin
                        phase_in = PH_TRAILER;
                        tc_in    = 3'd0;
                        expl_in  = 24'd0;
                     end else begin
                        phase_in = PH_SIZE;
                        size_in  = 16'd0;
                     end
                  end else begin
                     fbc_in = fbc_ff + 2'd1;
                  end
               end
               PH_SIZE: begin
                  size_in = size_shift;
                  if (fbc_ff >= 2'd1) begin
                     fbc_in = 2'd0;
                     if (size_shift == 16'd0) begin
                        phase_in = PH_RLE;
                     end else begin
                        phase_in = PH_DATA;
                        skip_in  = size_shift;
                     end
                  end else begin
                     fbc_in = fbc_ff + 2'd1;
                  end
               end
               PH_RLE: begin
                  if (fbc_ff < 2'd2) begin
                     size_in = size_shift;
                     fbc_in  = fbc_ff + 2'd1;
                  end else begin
                     finish = 1'b1;
                  end
               end
               PH_DATA: begin
                  skip_in = skip_dec;
                  if (skip_dec == 16'd0) begin
                     finish = 1'b1;
                  end
               end
               PH_TRAILER: begin
                  if (tc_ff < 3'd3) begin
                     expl_in = {expl_ff[15:0], item.patch_byte};
                  end
                  if (tc_ff < 3'd4) begin
                     tc_in = tc_ff + 3'd1;
                  end
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
            if (finish) begin
               if (rec_end > MAX_OUTPUT) begin
                  err_in = 1'b1;
               end else if (rec_end > CMP_W'(max_cur)) begin
                  max_end_in = rec_end[SIZE_W-1:0];
               end
               phase_in = PH_RECORD;
               fbc_in   = 2'd0;
               off_in   = 24'd0;
            end
         end
         if (item.last_byte) begin
            result_in.ok          = 1'b0;
            result_in.output_size = '0;
            if (!err_in && phase_in == PH_TRAILER) begin
               if (tc_in == 3'd0 && CMP_W'(max_end_in) <= MAX_OUTPUT) begin
                  result_in.ok          = 1'b1;
                  result_in.output_size = max_end_in;
               end else if (tc_in == 3'd3 && CMP_W'(expl_in) <= MAX_OUTPUT) begin
                  result_in.ok          = 1'b1;
                  result_in.output_size = SIZE_W'(expl_in);
               end
            end
            rsp_valid_in = 1'b1;
            phase_in   = PH_HEADER;
            fbc_in     = 2'd0;
            off_in     = 24'd0;
            size_in    = 16'd0;
            skip_in    = 16'd0;
            expl_in    = 24'd0;
            tc_in      = 3'd0;
            total_in   = 3'd0;
            err_in     = 1'b0;
            max_end_in = input_size_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_size_ff <= '0;
         phase_ff      <= PH_HEADER;
         fbc_ff        <= 2'd0;
         off_ff        <= 24'd0;
         size_ff       <= 16'd0;
         skip_ff       <= 16'd0;
         max_end_ff    <= '0;
         expl_ff       <= 24'd0;
         tc_ff         <= 3'd0;
         total_ff      <= 3'd0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            input_size_ff <= csr_wdata;
         end
         phase_ff     <= phase_in;
         fbc_ff       <= fbc_in;
         off_ff       <= off_in;
         size_ff      <= size_in;
         skip_ff      <= skip_in;
         max_end_ff   <= max_end_in;
         expl_ff      <= expl_in;
         tc_ff        <= tc_in;
         total_ff     <= total_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   `IPO_ASSERT(a_last_gives_result, clock, reset, last_take |=> rsp_valid_ff, "final byte gave no result")
   `IPO_ASSERT(a_bad_size_zero, clock, reset, (rsp_valid_ff && !result_ff.ok) |-> (result_ff.output_size == '0), "failed result with nonzero size")
   `IPO_ASSERT(a_ok_in_range, clock, reset, (rsp_valid_ff && result_ff.ok) |-> (CMP_W'(result_ff.output_size) <= MAX_OUTPUT), "size above limit reported ok")
   `IPO_ASSERT(a_rearm, clock, reset, last_take |=> (phase_ff == PH_HEADER && total_ff == 3'd0 && !err_ff), "parser did not re-arm after final byte")

endmodule

>>> rtl/ips_patch_output_size.sv
// ----------------------------------------------------------------------------
// ips_patch_output_size
// Patch file parser that reports the resulting image size.
// ----------------------------------------------------------------------------
// The block takes one patch byte per clock cycle, back to back, and every byte
// is a request on the req_ channel with tlast on the final byte of the file.
// Each byte passes an input register and then updates the parser state, so
// the sustained rate is one byte per cycle unless intake pauses; the result
// is held on rsp_ in an output register until it is taken. Intake pauses
// only when a final byte finds the previous result still waiting. The user
// must write input_size through csr_ only while no file is in flight (the
// block does not enforce this); it is sampled on the first byte of a file.
module ips_patch_output_size (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [25:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] patch_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [25:0] output_size, [31:26] zero
   output logic        rsp_tuser    // [0] ok
);
   import ipo_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       take;
   result_type result;

   ipo_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ipo_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .result     (result)
   );

   assign rsp_tdata = {(32 - SIZE_W)'(0), result.output_size};
   assign rsp_tuser = result.ok;

endmodule

>>> bench/ips_patch_output_size_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ips_patch_output_size_tb
// Streams patch files through the checker and compares each reported size.
// ----------------------------------------------------------------------------
// Patch files are built as byte queues: well-formed files with random records,
// truncated files, damaged headers and plain noise. A parser model in the
// bench predicts ok and output_size for every file, and the monitor compares
// each result as it is taken. Phases change input_size and the idling of both
// channels, and one phase holds off the result channel to back up the input.
// ----------------------------------------------------------------------------
module ips_patch_output_size_tb;
   import ipo_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_BYTES = 40;
   localparam int HOLD_CYCLES = 300;
   localparam logic [39:0] HDR_TEXT = "PATCH";

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [25:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] patch_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [25:0] output_size, [31:26] zero
   logic        rsp_tuser;        // [0] ok

   item_type    patch_stream[$];
   result_type  expected_sizes[$];
   logic [7:0]  file_buf[$];
   int          bytes_sent = 0;
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        pressure_on = 1'b0;
   logic        rsp_hold = 1'b0;

   logic [25:0] cfg_input_size;
   phase_type   prs_phase;
   logic [2:0]  field_cnt;
   logic [23:0] rec_offset;
   logic [15:0] rec_size;
   logic [16:0] skip_left;
   logic [25:0] max_end;
   logic [23:0] explicit_sz;
   logic [2:0]  trailer_cnt;
   logic [2:0]  hdr_cnt;
   logic        err_seen;

   ips_patch_output_size u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   task automatic rearm_parser();
      prs_phase = PH_HEADER;
      field_cnt = '0;
      rec_offset = '0;
      rec_size = '0;
      skip_left = '0;
      explicit_sz = '0;
      trailer_cnt = '0;
      hdr_cnt = '0;
      err_seen = 1'b0;
      max_end = cfg_input_size;
   endtask

   task automatic close_record(input logic [15:0] len);
      logic [31:0] end_pos;
      end_pos = 32'(rec_offset) + 32'(len);
      if (32'(rec_offset) > 32'(MAX_OUTPUT) ||
          32'(len) > 32'(MAX_OUTPUT) - 32'(rec_offset)) begin
         err_seen = 1'b1;
      end else if (end_pos > 32'(max_end)) begin
         max_end = end_pos[25:0];
      end
      prs_phase = PH_RECORD;
      field_cnt = '0;
      rec_offset = '0;
   endtask

   task automatic parse_patch_byte(input logic [7:0] b, input logic last);
      result_type  res;
      logic [31:0] sz;
      logic        good;
      if (prs_phase == PH_HEADER && hdr_cnt == 3'd0 && !err_seen) max_end = cfg_input_size;
      if (!err_seen) begin
         case (prs_phase)
            PH_HEADER: begin
               if (hdr_cnt >= HDR_LEN || b != HDR_TEXT[39 - 8*int'(hdr_cnt) -: 8]) begin
                  err_seen = 1'b1;
               end else begin
                  hdr_cnt = hdr_cnt + 3'd1;
                  if (hdr_cnt == HDR_LEN) begin
                     prs_phase = PH_RECORD;
                     field_cnt = '0;
                     rec_offset = '0;
                  end
               end
            end
            PH_RECORD: begin
               rec_offset = {rec_offset[15:0], b};
               field_cnt = field_cnt + 3'd1;
               if (field_cnt >= 3'd3) begin
                  field_cnt = '0;
                  if (rec_offset == EOF_MARK) begin
                     prs_phase = PH_TRAILER;
                     trailer_cnt = '0;
                     explicit_sz = '0;
                  end else begin
                     prs_phase = PH_SIZE;
                     rec_size = '0;
                  end
               end
            end
            PH_SIZE: begin
               rec_size = {rec_size[7:0], b};
               field_cnt = field_cnt + 3'd1;
               if (field_cnt >= 3'd2) begin
                  field_cnt = '0;
                  if (rec_size == 16'd0) begin
                     prs_phase = PH_RLE;
                  end else begin
                     prs_phase = PH_DATA;
                     skip_left = 17'(rec_size);
                  end
               end
            end
            PH_RLE: begin
               if (field_cnt < 3'd2) rec_size = {rec_size[7:0], b};
               field_cnt = field_cnt + 3'd1;
               if (field_cnt >= 3'd3) close_record(rec_size);
            end
            PH_DATA: begin
               if (skip_left > 17'd0) skip_left = skip_left - 17'd1;
               if (skip_left == 17'd0) close_record(rec_size);
            end
            PH_TRAILER: begin
               if (trailer_cnt < 3'd3) explicit_sz = {explicit_sz[15:0], b};
               if (trailer_cnt < 3'd4) trailer_cnt = trailer_cnt + 3'd1;
            end
            default: begin
               err_seen = 1'b1;
            end
         endcase
      end
      if (last) begin
         good = 1'b0;
         sz = '0;
         if (!err_seen && prs_phase == PH_TRAILER) begin
            if (trailer_cnt == 3'd0) begin
               sz = 32'(max_end);
               good = 1'b1;
            end else if (trailer_cnt == 3'd3) begin
               sz = 32'(explicit_sz);
               good = 1'b1;
            end
            if (good && sz > 32'(MAX_OUTPUT)) good = 1'b0;
         end
         if (!good) sz = '0;
         res.ok = good;
         res.output_size = sz[25:0];
         expected_sizes = {expected_sizes, res};
         rearm_parser();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [32:0] got,
                                  input logic [32:0] want);
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : drive_req
      item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) parse_patch_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (patch_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = patch_stream.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.patch_byte;
               req_tlast <= nxt.last_byte;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sizes.size() == 0) begin
               report_mismatch("unexpected result", {rsp_tuser, rsp_tdata}, '0);
            end else begin
               want = expected_sizes.pop_front();
               if (rsp_tuser !== want.ok) begin
                  report_mismatch("ok", 33'(rsp_tuser), 33'(want.ok));
               end
               if (rsp_tdata !== {6'b0, want.output_size}) begin
                  report_mismatch("output_size", 33'(rsp_tdata), 33'(want.output_size));
               end
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      wait (pressure_on);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic put_be(input logic [39:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) file_buf = {file_buf, v[8*i +: 8]};
   endtask

   task automatic send_file();
      item_type it;
      for (int i = 0; i < file_buf.size(); i++) begin
         it.patch_byte = file_buf[i];
         it.last_byte = (i == file_buf.size() - 1);
         patch_stream = {patch_stream, it};
      end
      bytes_sent += file_buf.size();
      file_buf.delete();
   endtask

   task automatic gen_file();
      int          kind;
      int          r;
      int          size;
      int          cut;
      logic [23:0] off;
      kind = $urandom_range(99);
      if (kind < 80) begin
         put_be(HDR_TEXT, 5);
         repeat ($urandom_range(4)) begin
            case ($urandom_range(2))
               0: off = 24'($urandom_range(4095));
               1: off = 24'($urandom);
               default: off = 24'hFFFF00 | 24'($urandom_range(255));
            endcase
            put_be(40'(off), 3);
            if ($urandom_range(3) == 0) begin
               put_be(40'd0, 2);
               put_be(40'($urandom_range(65535)), 2);
               put_be(40'($urandom_range(255)), 1);
            end else begin
               r = $urandom_range(99);
               size = (r < 80) ? $urandom_range(1, 8) :
                      (r < 98) ? $urandom_range(9, 64) : $urandom_range(200, 600);
               put_be(40'(size), 2);
               repeat (size) put_be(40'($urandom_range(255)), 1);
            end
         end
         put_be(40'(EOF_MARK), 3);
         r = $urandom_range(9);
         if (r < 3) put_be(40'($urandom), 3);
         else if (r == 3) put_be(40'($urandom), $urandom_range(1, 2));
         else if (r == 4) put_be(40'($urandom), $urandom_range(4, 5));
         if (kind >= 65) begin
            cut = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut) void'(file_buf.pop_back());
         end
      end else if (kind < 90) begin
         put_be(HDR_TEXT ^ (40'd1 << $urandom_range(39)), 5);
         repeat ($urandom_range(6)) put_be(40'($urandom_range(255)), 1);
      end else begin
         repeat ($urandom_range(1, 12)) put_be(40'($urandom_range(255)), 1);
      end
   endtask

   task automatic wait_drained();
      while (patch_stream.size() != 0 || req_tvalid || expected_sizes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_input_size(input logic [25:0] v);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      cfg_input_size = v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random_phase(input logic [25:0] size_cfg, input int send_pct,
                                   input int recv_pct);
      int start;
      write_input_size(size_cfg);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      put_be(HDR_TEXT, 5);
      put_be(40'(EOF_MARK), 3);
      send_file();
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
         gen_file();
         send_file();
         if ($urandom_range(9) == 0) wait_drained();
      end
   endtask

   initial begin
      cfg_input_size = '0;
      rearm_parser();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_input_size('0);
      put_be(HDR_TEXT, 5);
      put_be(40'(EOF_MARK), 3);
      send_file();
      put_be(40'hFF, 1);
      send_file();
      put_be(HDR_TEXT, 5);
      send_file();
      put_be(HDR_TEXT, 5);
      put_be(40'(EOF_MARK), 3);
      put_be(40'hFFFFFF, 3);
      send_file();

      run_random_phase(MAX_OUTPUT[25:0], 0, 0);
      run_random_phase(26'($urandom_range(0, 1 << 20)), 45, 0);
      run_random_phase(26'h3FFFFFF, 0, 45);
      run_random_phase(26'($urandom_range(0, 33554432)), 24, 24);

      write_input_size(26'd1);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      pressure_on = 1'b1;
      repeat (20) begin
         if ($urandom_range(1) == 0) begin
            put_be(HDR_TEXT, 5);
            put_be(40'(EOF_MARK), 3);
            if ($urandom_range(1) == 0) put_be(40'($urandom), 3);
         end else begin
            repeat ($urandom_range(1, 3)) put_be(40'($urandom_range(255)), 1);
         end
         send_file();
      end

      run_random_phase(26'($urandom_range(0, 4096)), 24, 24);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
